// ===== rtl/sha_pkg.sv =====
`default_nettype none
package sha_pkg;

    typedef logic [31:0] word_t;

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam word_t INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // push word source
    localparam logic [2:0] SRC_DATA = 3'd0;
    localparam logic [2:0] SRC_ZERO = 3'd1;
    localparam logic [2:0] SRC_LENH = 3'd2;
    localparam logic [2:0] SRC_LENL = 3'd3;
    localparam logic [2:0] SRC_MARK = 3'd4;

    typedef struct packed {
        logic       push;
        logic [2:0] src;
        logic       add_len;
        logic       start;
        logic       round;
        logic       finish;
        logic       reset_msg;
        logic [2:0] out_idx;
    } cmd_t;

    typedef struct packed {
        logic [3:0] wpos;
        logic [5:0] rnd;
    } stat_t;

    function automatic word_t ror32(word_t v, int s);
        ror32 = (v >> s) | (v << (32 - s));
    endfunction

endpackage
`default_nettype wire

// ===== rtl/sha_datapath.sv =====
`default_nettype none
module sha_datapath
    import sha_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cmd_t        cmd,
    input  wire word_t       data_in,
    input  wire logic [2:0]  count_in,
    output stat_t            stat,
    output word_t            digest_out
);

    word_t       w_reg [16];
    word_t       h_reg [8];
    word_t       v_reg [8];
    logic [63:0] len_reg;
    logic [3:0]  wpos_reg;
    logic [5:0]  rnd_reg;
    word_t       push_word;
    logic [2:0]  cnt;
    word_t       mask;
    word_t       s0, s1, wnew, t1, t2, wcur;

    always_comb begin
        cnt = (count_in > 3'd4) ? 3'd4 : count_in;
        case (cnt[1:0])
            2'd0:    mask = 32'h00000000;
            2'd1:    mask = 32'hff000000;
            2'd2:    mask = 32'hffff0000;
            default: mask = 32'hffffff00;
        endcase
        case (cmd.src)
            SRC_DATA: push_word = cnt[2] ? data_in
                : ((data_in & mask) | (32'h80000000 >> {cnt[1:0], 3'b000}));
            SRC_ZERO: push_word = 32'h0;
            SRC_LENH: push_word = len_reg[63:32];
            SRC_LENL: push_word = len_reg[31:0];
            SRC_MARK: push_word = 32'h80000000;
            default:  push_word = 32'h0;
        endcase
    end

    // schedule: w_reg holds sched[i..i+15] as a shift line
    always_comb begin
        wcur = w_reg[0];
        s0 = ror32(w_reg[1], 7) ^ ror32(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = ror32(w_reg[14], 17) ^ ror32(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wnew = s1 + w_reg[9] + s0 + w_reg[0];
        t1 = v_reg[7] + (ror32(v_reg[4], 6) ^ ror32(v_reg[4], 11) ^ ror32(v_reg[4], 25))
            + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + ROUND_K[rnd_reg] + wcur;
        t2 = (ror32(v_reg[0], 2) ^ ror32(v_reg[0], 13) ^ ror32(v_reg[0], 22))
            + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) h_reg[i] <= INIT_HASH[i];
            len_reg  <= '0;
            wpos_reg <= '0;
            rnd_reg  <= '0;
        end else begin
            if (cmd.add_len) begin
                len_reg <= len_reg + {58'd0, cnt, 3'b000};
            end
            if (cmd.push) begin
                w_reg[wpos_reg] <= push_word;
                wpos_reg <= wpos_reg + 4'd1;
            end
            if (cmd.start) begin
                for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                rnd_reg <= '0;
            end
            if (cmd.round) begin
                for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                w_reg[15] <= wnew;
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
                rnd_reg <= rnd_reg + 6'd1;
            end
            if (cmd.finish) begin
                for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
            end
            if (cmd.reset_msg) begin
                for (int i = 0; i < 8; i++) h_reg[i] <= INIT_HASH[i];
                len_reg  <= '0;
                wpos_reg <= '0;
            end
        end
    end

    assign stat.wpos  = wpos_reg;
    assign stat.rnd   = rnd_reg;
    assign digest_out = h_reg[cmd.out_idx];

endmodule
`default_nettype wire

// ===== rtl/sha_ctrl.sv =====
`default_nettype none
module sha_ctrl
    import sha_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       last_in,
    input  wire logic [2:0] count_in,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [2:0]      out_idx,
    input  wire stat_t      stat,
    output cmd_t            cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_FIN   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       pad_reg, pad_next;
    logic       fl_reg, fl_next;
    logic       one_reg, one_next;
    logic       ext_reg, ext_next;
    logic [2:0] idx_reg, idx_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign out_idx = idx_reg;

    always_comb begin
        state_next = state_reg;
        pad_next   = pad_reg;
        fl_next    = fl_reg;
        one_next   = one_reg;
        ext_next   = ext_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.src    = SRC_DATA;
        cmd.out_idx = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.push    = 1'b1;
                    cmd.add_len = 1'b1;
                    if (last_in) begin
                        pad_next = 1'b1;
                        one_next = (count_in >= 3'd4);
                        // marker at word 14 leaves no room for the length
                        ext_next = (count_in < 3'd4) && (stat.wpos == 4'd14);
                    end
                    if (stat.wpos == 4'd15) begin
                        cmd.start  = 1'b1;
                        state_next = ST_ROUND;
                    end else if (last_in) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                cmd.push = 1'b1;
                if (one_reg) begin
                    cmd.src  = SRC_MARK;
                    ext_next = (stat.wpos == 4'd14);
                end else if (ext_reg) begin
                    cmd.src = SRC_ZERO;
                end else if (stat.wpos == 4'd14) begin
                    cmd.src = SRC_LENH;
                end else if (stat.wpos == 4'd15) begin
                    cmd.src = SRC_LENL;
                end else begin
                    cmd.src = SRC_ZERO;
                end
                one_next = 1'b0;
                if (stat.wpos == 4'd15) begin
                    cmd.start  = 1'b1;
                    fl_next    = (cmd.src == SRC_LENL);
                    ext_next   = 1'b0;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                cmd.round = 1'b1;
                if (stat.rnd == 6'd63) state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                if (fl_reg) begin
                    idx_next   = 3'd0;
                    state_next = ST_OUT;
                end else if (pad_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7) begin
                        cmd.reset_msg = 1'b1;
                        pad_next   = 1'b0;
                        fl_next    = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pad_reg   <= 1'b0;
            fl_reg    <= 1'b0;
            one_reg   <= 1'b0;
            ext_reg   <= 1'b0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            pad_reg   <= pad_next;
            fl_reg    <= fl_next;
            one_reg   <= one_next;
            ext_reg   <= ext_next;
            idx_reg   <= idx_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/sha256_hasher_core.sv =====
// a word that completes a block starts a compression, and s_ready stays low until it ends
// throughput: one round per cycle
// last word: padding words are pushed, then 1 or 2 compressions, then 8 digest words
// reset: synchronous active-low aresetn loads the initial hash and clears length
`default_nettype none
module sha256_hasher_core
    import sha_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_data_word,
    input  wire logic [2:0]  s_byte_count,
    input  wire logic        s_last_word,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_digest_word,
    output logic [2:0]       m_word_index,
    output logic             m_digest_last
);

    cmd_t  cmd;
    stat_t stat;
    logic [2:0] idx;

    sha_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .last_in(s_last_word), .count_in(s_byte_count), .m_valid(m_valid),
        .m_ready(m_ready), .out_idx(idx), .stat(stat), .cmd(cmd)
    );

    sha_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .data_in(s_data_word),
        .count_in(s_last_word ? s_byte_count : 3'd4), .stat(stat),
        .digest_out(m_digest_word)
    );

    assign m_word_index  = idx;
    assign m_digest_last = (idx == 3'd7);

endmodule
`default_nettype wire
